// ===== hdl/spiadc_pkg.sv =====
// shared types and constants for the serial converter read sequencer
package spiadc_pkg;

    localparam int VALUE_W    = 12;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int CHAN_W     = 4;

    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 4'd7;
    localparam logic [7:0]         CMD_BASE   = 8'h18;
    localparam logic [VALUE_W-1:0] FULL_SCALE = 12'd2048;

    // input beat, lowest bit first: start_req, channel, current_mode, miso_level
    typedef struct packed {
        logic              pad;
        logic              miso_level;
        logic              current_mode;
        logic [CHAN_W-1:0] channel;
        logic              start_req;
    } in_beat_t;

    // result beat, lowest bit first: select, clock, mosi, busy, done, error, value
    typedef struct packed {
        logic [5:0]         pad;
        logic [VALUE_W-1:0] value;
        logic               error;
        logic               done_res;
        logic               busy_res;
        logic               mosi_level;
        logic               clock_level;
        logic               select_level;
    } out_beat_t;

endpackage

// ===== hdl/spi_adc_read_sequencer.sv =====
// serial converter read sequencer, one pin update per input beat
//
//  channel | ports             | beat contents (lowest bit first)
//  --------+-------------------+---------------------------------------------------
//  input   | s_tvalid/s_tready | start_req, channel[3:0], current_mode, miso_level
//  result  | m_tvalid/m_tready | select, clock, mosi, busy, done, error, value[11:0]
//
//  one input beat is one tick and yields exactly one result beat in the cycle after it
//  throughput is one beat per cycle while the result side does not stall: the whole
//  tick is a single pass of logic from the input port into the result register
//  a read takes 3 + 3*COMMAND_BITS + 2*READ_BITS ticks plus one finishing tick
//  aresetn (synchronous, active low) idles the sequencer, pins select 0 clock 1 mosi 0
//  a stalled result register holds its beat and stalls the input side with it
module spi_adc_read_sequencer #(
    parameter int COMMAND_BITS = 5,
    parameter int READ_BITS    = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_req, channel[3:0], current_mode, miso_level, zero pad
    input  logic [spiadc_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // select, clock, mosi, busy, done, error, value[11:0], zero pad
    output logic [spiadc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import spiadc_pkg::*;

    // tick schedule: 1 clock high, 2 select high, then command, then read
    localparam int CMD_START  = 3;
    localparam int READ_START = CMD_START + 3 * COMMAND_BITS;
    localparam int LAST_STEP  = READ_START + 2 * READ_BITS;
    localparam int PW         = $clog2(LAST_STEP + 1);

    localparam logic [PW-1:0] STEP_IDLE  = '0;
    localparam logic [PW-1:0] STEP_WAKE  = PW'(1);
    localparam logic [PW-1:0] STEP_SEL   = PW'(2);
    localparam logic [PW-1:0] STEP_READ  = PW'(READ_START);
    localparam logic [PW-1:0] STEP_LAST  = PW'(LAST_STEP);
    localparam logic          READ_PAR   = STEP_READ[0];

    // sequencer state
    logic [PW-1:0]           phase_reg,  phase_next;
    logic [1:0]              sub_reg,    sub_next;   // tick within a command bit
    logic [COMMAND_BITS-1:0] cmd_reg,    cmd_next;
    logic [READ_BITS-1:0]    data_reg,   data_next;
    logic                    mode_reg,   mode_next;
    logic                    sel_reg,    sel_next;
    logic                    clk_reg,    clk_next;
    logic                    mosi_reg,   mosi_next;

    // result register
    logic                    m_tvalid_reg;
    out_beat_t               m_beat_reg, m_beat_next;

    in_beat_t                in_beat;
    logic                    accept;
    logic [7:0]              cmd_byte;
    logic [READ_BITS+VALUE_W-1:0] wide_raw;
    logic [VALUE_W-1:0]      raw;
    logic [VALUE_W-1:0]      fin_value;

    assign in_beat  = in_beat_t'(s_tdata);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_beat_reg;

    // command byte: channel in bits 4:2 with start and single-ended marks, moved up by 3
    assign cmd_byte = {({in_beat.channel[2:0], 2'b00} | CMD_BASE[4:0]), 3'b000};

    // raw reading drops the last sampled bit
    assign wide_raw  = {{VALUE_W{1'b0}}, data_reg} >> 1;
    assign raw       = wide_raw[VALUE_W-1:0];
    assign fin_value = !mode_reg ? raw
                     : (raw > FULL_SCALE) ? '0 : FULL_SCALE - raw;

    always_comb begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        mode_next   = mode_reg;
        sel_next    = sel_reg;
        clk_next    = clk_reg;
        mosi_next   = mosi_reg;
        m_beat_next = '0;

        if (phase_reg == STEP_IDLE) begin
            if (in_beat.start_req) begin
                if (in_beat.channel > CHAN_MAX) begin
                    m_beat_next.done_res = 1'b1;
                    m_beat_next.error    = 1'b1;
                end else begin
                    cmd_next   = cmd_byte[7 -: COMMAND_BITS];
                    data_next  = '0;
                    mode_next  = in_beat.current_mode;
                    sel_next   = 1'b0;
                    sub_next   = 2'd0;
                    phase_next = STEP_WAKE;
                    m_beat_next.busy_res = 1'b1;
                end
            end
        end else if (phase_reg >= STEP_LAST) begin
            sel_next   = 1'b0;
            phase_next = STEP_IDLE;
            m_beat_next.done_res = 1'b1;
            m_beat_next.value    = fin_value;
        end else begin
            m_beat_next.busy_res = 1'b1;
            phase_next = phase_reg + PW'(1);
            if (phase_reg == STEP_WAKE) begin
                clk_next = 1'b1;
            end else if (phase_reg == STEP_SEL) begin
                sel_next = 1'b1;
            end else if (phase_reg < STEP_READ) begin
                sub_next = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                unique case (sub_reg)
                    2'd0: begin
                        mosi_next = ~cmd_reg[COMMAND_BITS-1];
                        cmd_next  = cmd_reg << 1;
                    end
                    2'd1: clk_next = 1'b0;
                    default: clk_next = 1'b1;
                endcase
            end else if ((phase_reg[0] ^ READ_PAR) == 1'b0) begin
                clk_next = 1'b0;
            end else begin
                clk_next  = 1'b1;
                data_next = {data_reg[READ_BITS-2:0], ~in_beat.miso_level};
            end
        end

        m_beat_next.select_level = sel_next;
        m_beat_next.clock_level  = clk_next;
        m_beat_next.mosi_level   = mosi_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= STEP_IDLE;
            sub_reg      <= 2'd0;
            cmd_reg      <= '0;
            data_reg     <= '0;
            mode_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            clk_reg      <= 1'b1;
            mosi_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                sub_reg   <= sub_next;
                cmd_reg   <= cmd_next;
                data_reg  <= data_next;
                mode_reg  <= mode_next;
                sel_reg   <= sel_next;
                clk_reg   <= clk_next;
                mosi_reg  <= mosi_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    // payload register, loaded with each accepted tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_beat_reg <= m_beat_next;
        end
    end

endmodule

// ===== tb/spiadc_pin_checker.sv =====
`timescale 1ns / 1ps
// pin sequence predictor and result-beat checker for the converter read sequencer
module spiadc_pin_checker #(
    parameter int CMD_BITS  = 5,
    parameter int DATA_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [spiadc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [spiadc_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                                mismatches,
    output int                                pending
);
    import spiadc_pkg::*;

    localparam int CMD_FIRST  = 3;
    localparam int DATA_FIRST = CMD_FIRST + 3 * CMD_BITS;
    localparam int FINAL_STEP = DATA_FIRST + 2 * DATA_BITS;

    // shadow of the sequencer state
    logic [5:0]           step;
    logic [CMD_BITS-1:0]  cmd_bits;
    logic [DATA_BITS-1:0] sampled;
    logic                 mode_q;
    logic                 sel_pin;
    logic                 clk_pin;
    logic                 mosi_pin;

    out_beat_t pin_forecast[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [VALUE_W-1:0] reading();
        logic [VALUE_W-1:0] raw;
        raw = VALUE_W'(sampled >> 1);
        if (!mode_q)
            return raw;
        return (raw > FULL_SCALE) ? '0 : FULL_SCALE - raw;
    endfunction

    // one tick: update the shadow state and return the pins and flags it reports
    function automatic out_beat_t advance_tick(in_beat_t b);
        out_beat_t  r;
        logic [7:0] cmd_byte;
        int         ofs;
        r = '0;
        if (step == 6'd0) begin
            if (b.start_req) begin
                if (b.channel > CHAN_MAX) begin
                    r.done_res = 1'b1;
                    r.error    = 1'b1;
                end else begin
                    cmd_byte = ({4'd0, b.channel} << 2) | CMD_BASE;
                    cmd_byte = cmd_byte << 3;
                    cmd_bits = cmd_byte[7 -: CMD_BITS];
                    sampled  = '0;
                    mode_q   = b.current_mode;
                    sel_pin  = 1'b0;
                    step     = 6'd1;
                    r.busy_res = 1'b1;
                end
            end
        end else if (int'(step) >= FINAL_STEP) begin
            sel_pin    = 1'b0;
            r.done_res = 1'b1;
            r.value    = reading();
            step       = 6'd0;
        end else begin
            r.busy_res = 1'b1;
            if (step == 6'd1) begin
                clk_pin = 1'b1;
            end else if (step == 6'd2) begin
                sel_pin = 1'b1;
            end else if (int'(step) < DATA_FIRST) begin
                ofs = (int'(step) - CMD_FIRST) % 3;
                unique case (ofs)
                    0: begin
                        mosi_pin = ~cmd_bits[CMD_BITS-1];
                        cmd_bits = cmd_bits << 1;
                    end
                    1: clk_pin = 1'b0;
                    default: clk_pin = 1'b1;
                endcase
            end else begin
                ofs = (int'(step) - DATA_FIRST) % 2;
                if (ofs == 0) begin
                    clk_pin = 1'b0;
                end else begin
                    clk_pin = 1'b1;
                    sampled = {sampled[DATA_BITS-2:0], ~b.miso_level};
                end
            end
            step = step + 6'd1;
        end
        r.select_level = sel_pin;
        r.clock_level  = clk_pin;
        r.mosi_level   = mosi_pin;
        return r;
    endfunction

    function automatic string show(out_beat_t b);
        return $sformatf("sel %0d clk %0d mosi %0d busy %0d done %0d err %0d value %0d",
                         b.select_level, b.clock_level, b.mosi_level, b.busy_res,
                         b.done_res, b.error, b.value);
    endfunction

    task automatic note_failure(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        out_beat_t got;
        out_beat_t want;
        if (!aresetn) begin
            step     = '0;
            cmd_bits = '0;
            sampled  = '0;
            mode_q   = 1'b0;
            sel_pin  = 1'b0;
            clk_pin  = 1'b1;
            mosi_pin = 1'b0;
            pin_forecast.delete();
        end else begin
            // results first: a beat leaving now was caused by an earlier tick
            if (m_tvalid && m_tready) begin
                got = out_beat_t'(m_tdata);
                if (pin_forecast.size() == 0) begin
                    note_failure({"result beat with nothing expected: ", show(got)});
                end else begin
                    want = pin_forecast.pop_front();
                    if (got.select_level !== want.select_level ||
                        got.clock_level  !== want.clock_level  ||
                        got.mosi_level   !== want.mosi_level   ||
                        got.busy_res     !== want.busy_res     ||
                        got.done_res     !== want.done_res     ||
                        got.error        !== want.error        ||
                        got.value        !== want.value)
                        note_failure({"expected ", show(want), " got ", show(got)});
                end
            end
            if (s_tvalid && s_tready)
                pin_forecast.push_back(advance_tick(in_beat_t'(s_tdata)));
        end
        pending = pin_forecast.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// stimulus, flow control and verdict for the converter read sequencer
module tb_top;
    import spiadc_pkg::*;

    // ticks after the start beat: 2 setup, 3 per command bit, 2 per read bit, 1 finish
    localparam int READ_TICKS  = 3 + 3 * 5 + 2 * 12;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_BEATS = 50;
    // sender idle and receiver stall percentages, one pair per phase
    localparam int IDLE_PLAN[4]  = '{0, 63, 0, 16};
    localparam int STALL_PLAN[4] = '{0, 0, 63, 16};

    typedef enum int {
        MISO_RANDOM,
        MISO_ALL_LOW,
        MISO_ALL_HIGH,
        MISO_TOGGLE
    } miso_pattern_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int mismatches;
    int pending;
    // coverage tallies for the summary
    int n_beats   = 0;
    int n_reads   = 0;
    int n_rejects = 0;
    int n_current = 0;

    always #5 aclk = ~aclk;

    spi_adc_read_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spiadc_pin_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver side: random backpressure at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: give up when neither channel moves a beat for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[spi_adc_read_sequencer] ERROR");
            $finish;
        end
    end

    function automatic in_beat_t make_beat(logic start, logic [3:0] chan, logic mode,
                                           logic miso);
        in_beat_t b;
        b              = '0;
        b.start_req    = start;
        b.channel      = chan;
        b.current_mode = mode;
        b.miso_level   = miso;
        return b;
    endfunction

    function automatic logic miso_for(miso_pattern_e pat, int idx);
        unique case (pat)
            MISO_ALL_LOW:  return 1'b0;
            MISO_ALL_HIGH: return 1'b1;
            MISO_TOGGLE:   return idx[0];
            default:       return 1'($urandom_range(1));
        endcase
    endfunction

    // present one tick, idling first at the phase rate, and wait for the handshake
    // valid stays high between back-to-back beats so it is never dropped and
    // raised in the same step
    task automatic send_beat(input in_beat_t b);
        logic hit;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        // ready is looked at mid-cycle, where every input has settled
        do begin
            @(negedge aclk);
            hit = s_tready;
            @(posedge aclk);
        end while (!hit);
        n_beats++;
    endtask

    // one start beat, then, unless the channel is rejected, the whole read with random
    // start requests that the busy sequencer must ignore
    task automatic run_read(logic [3:0] chan, logic mode, miso_pattern_e pat);
        send_beat(make_beat(1'b1, chan, mode, 1'($urandom_range(1))));
        if (chan > CHAN_MAX) begin
            n_rejects++;
            return;
        end
        n_reads++;
        if (mode)
            n_current++;
        for (int i = 0; i < READ_TICKS; i++)
            send_beat(make_beat(1'($urandom_range(1)), 4'($urandom_range(15)),
                                1'($urandom_range(1)), miso_for(pat, i)));
    endtask

    // a few idle ticks, then mostly good reads and now and then a rejected channel
    task automatic random_sequence();
        int            gap;
        miso_pattern_e pat;
        gap = $urandom_range(3);
        repeat (gap)
            send_beat(make_beat(1'b0, 4'($urandom_range(15)), 1'($urandom_range(1)),
                                1'($urandom_range(1))));
        pat = ($urandom_range(9) < 6) ? MISO_RANDOM : miso_pattern_e'($urandom_range(3));
        if ($urandom_range(99) < 15)
            run_read(4'($urandom_range(15, 8)), 1'($urandom_range(1)), pat);
        else
            run_read(4'($urandom_range(7)), 1'($urandom_range(1)), pat);
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // idle ticks hold the pins, rejected channels finish at once with an error
        send_beat(make_beat(1'b0, 4'hF, 1'b1, 1'b1));
        send_beat(make_beat(1'b0, 4'h0, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 4'd8, 1'b0, 1'b0));
        send_beat(make_beat(1'b1, 4'd15, 1'b1, 1'b1));
        send_beat(make_beat(1'b1, 4'd12, 1'b1, 1'b0));
        send_beat(make_beat(1'b0, 4'd3, 1'b1, 1'b0));
        // extremes of the reading: zero and full scale, raw and current mode
        run_read(4'd0, 1'b1, MISO_ALL_HIGH);
        run_read(4'd7, 1'b1, MISO_ALL_LOW);
        run_read(4'd5, 1'b0, MISO_ALL_LOW);
        run_read(4'd2, 1'b0, MISO_TOGGLE);
        run_read(4'd1, 1'b0, MISO_ALL_HIGH);
        drain();
        @(posedge aclk);

        for (int p = 0; p < 4; p++) begin
            int phase_start;
            @(negedge aclk);
            idle_pct  = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            @(posedge aclk);
            phase_start = n_beats;
            while (n_beats - phase_start < PHASE_BEATS)
                random_sequence();
            drain();
            @(posedge aclk);
        end

        // the block answers in the cycle after each accepted tick, so a short tail suffices
        repeat (4) @(posedge aclk);

        $display("covered %0d ticks over four flow-control phases", n_beats);
        $display("%0d full reads (%0d in current mode) and %0d rejected channels",
                 n_reads, n_current, n_rejects);
        if (mismatches == 0 && pending == 0) begin
            $display("[spi_adc_read_sequencer] OK");
        end else begin
            $display("[spi_adc_read_sequencer] ERROR");
        end
        $finish;
    end

endmodule
